// File: hdl/radius_nearest_group_select_top_assert.svh
// Assertion macros shared by the group selection block.
`ifndef RADIUS_NEAREST_GROUP_SELECT_TOP_ASSERT_SVH
`define RADIUS_NEAREST_GROUP_SELECT_TOP_ASSERT_SVH
// Implication in the same cycle.
`define RNGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication in the following cycle.
`define RNGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/rngs_pkg.sv
// Package with constants and shared types of the group selection block.
package rngs_pkg;
  localparam int MAX_CANDIDATES = 64;
  localparam int MAX_GROUP      = 64;
  localparam int IDX_W  = $clog2(MAX_CANDIDATES);
  localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
  localparam int KEPT_W = $clog2(MAX_GROUP);
  localparam int MEMB_W = 7;
  localparam int RAD_W  = 23;
  localparam int ID_W   = 32;
  localparam int MAP_W  = 16;
  localparam int POS_W  = 24;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = SQ_W;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = RAD_W;

  localparam logic [CFG_A_W-1:0] CFG_MIN_MEMBERS = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_MAX_MEMBERS = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_RADIUS      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [MAP_W-1:0]        map;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } cand_t;

  localparam int CAND_W = $bits(cand_t);

  typedef struct packed {
    logic load;
    logic start;
    logic idx_inc;
    logic rd;
    logic seed_cmp;
    logic pass_clr;
    logic sq_step;
    logic rank_cmp;
    logic pick;
    logic emit_seed;
    logic pick_rd;
    logic emit_pick;
    logic emit_none;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic too_few;
    logic idx_last;
    logic skip;
    logic sub_last;
    logic found;
    logic limit_reached;
    logic group_low;
    logic kept_zero;
    logic emit_last;
    logic out_free;
  } stat_t;
endpackage

// File: hdl/rngs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rngs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: hdl/rngs_datapath.sv
// Datapath: candidate store, distance unit, ranking registers and result register.
`include "radius_nearest_group_select_top_assert.svh"
module rngs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rngs_pkg::cmd_t             cmd,
  output rngs_pkg::stat_t            stat,
  input  logic                       cfg_wr_en,
  input  logic [rngs_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [rngs_pkg::CFG_D_W-1:0] cfg_wdata,
  input  logic [rngs_pkg::ID_W-1:0]  in_candidate_id,
  input  logic [rngs_pkg::MAP_W-1:0] in_map_number,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [rngs_pkg::ID_W-1:0]  out_member_id,
  output logic [rngs_pkg::MAP_W-1:0] out_group_map,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_x,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_y,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_z,
  output logic                       out_last_member
);
  import rngs_pkg::*;

  logic [MEMB_W-1:0] min_r, max_r;
  logic [RAD_W-1:0]  radius_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;
  logic [1:0]        sub_r;
  logic [RSQ_W-1:0]  rsq_r;
  cand_t             seed_r;
  logic [IDX_W-1:0]  seed_idx_r;
  logic [MAX_CANDIDATES-1:0] chosen_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [ID_W-1:0]   best_id_r;
  logic [ACC_W-1:0]  bd_r, acc_r;
  logic [KEPT_W-1:0] kept_r, ptr_r;
  logic              out_valid_r;
  cand_t             rd_cand;
  logic [CAND_W-1:0] rd_data;
  logic [ID_W-1:0]   pick_data;
  logic [KEPT_W-1:0] limit;
  logic [MEMB_W-1:0] lim_clamp;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] diff_abs;
  logic [SQ_W-1:0]   prod;
  logic              in_range, better, store_wr, pick_wr;
  cand_t             wr_cand;

  assign store_wr = cmd.load && (count_r < CNT_W'(MAX_CANDIDATES));
  assign wr_cand  = '{id: in_candidate_id, map: in_map_number,
                      x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign rd_cand  = cand_t'(rd_data);
  assign pick_wr  = cmd.pick && found_r;

  rngs_ram #(.WIDTH(CAND_W), .DEPTH(MAX_CANDIDATES)) u_store (
    .clk(clk), .wr_en(store_wr), .wr_addr(count_r[IDX_W-1:0]), .wr_data(wr_cand),
    .rd_en(cmd.rd), .rd_addr(idx_r), .rd_data(rd_data)
  );

  rngs_ram #(.WIDTH(ID_W), .DEPTH(MAX_GROUP)) u_picks (
    .clk(clk), .wr_en(pick_wr), .wr_addr(kept_r), .wr_data(best_id_r),
    .rd_en(cmd.pick_rd), .rd_addr(ptr_r), .rd_data(pick_data)
  );

  always_comb begin
    priority if (max_r == '0) begin
      lim_clamp = MEMB_W'(1);
    end else if (max_r > MEMB_W'(MAX_GROUP)) begin
      lim_clamp = MEMB_W'(MAX_GROUP);
    end else begin
      lim_clamp = max_r;
    end
    limit = KEPT_W'(lim_clamp - MEMB_W'(1));
  end

  always_comb begin
    unique case (sub_r)
      2'd0:    diff = DIFF_W'(rd_cand.x) - DIFF_W'(seed_r.x);
      2'd1:    diff = DIFF_W'(rd_cand.y) - DIFF_W'(seed_r.y);
      default: diff = DIFF_W'(rd_cand.z) - DIFF_W'(seed_r.z);
    endcase
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    prod     = diff_abs * diff_abs;
  end

  assign in_range = acc_r <= ACC_W'(rsq_r);
  assign better   = !found_r || (acc_r < bd_r) ||
                    ((acc_r == bd_r) && (rd_cand.id < best_id_r));

  always_comb begin
    stat.too_few       = (count_r == '0) || (count_r < min_r);
    stat.idx_last      = ({1'b0, idx_r} == CNT_W'(count_r - CNT_W'(1)));
    stat.skip          = chosen_r[idx_r] || (idx_r == seed_idx_r) ||
                         (rd_cand.map != seed_r.map);
    stat.sub_last      = (sub_r == 2'd2);
    stat.found         = found_r;
    stat.limit_reached = (kept_r >= limit);
    stat.group_low     = (MEMB_W'(kept_r) + MEMB_W'(1)) < min_r;
    stat.kept_zero     = (kept_r == '0);
    stat.emit_last     = (ptr_r == KEPT_W'(kept_r - KEPT_W'(1)));
    stat.out_free      = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MEMB_W'(2);
      max_r       <= MEMB_W'(8);
      radius_r    <= RAD_W'(7680);
      count_r     <= '0;
      idx_r       <= '0;
      sub_r       <= '0;
      chosen_r    <= '0;
      found_r     <= 1'b0;
      kept_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_MIN_MEMBERS: min_r    <= cfg_wdata[MEMB_W-1:0];
          CFG_MAX_MEMBERS: max_r    <= cfg_wdata[MEMB_W-1:0];
          CFG_RADIUS:      radius_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (store_wr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.start || cmd.pass_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.pass_clr) begin
        found_r <= 1'b0;
      end else if (cmd.rank_cmp && in_range && better) begin
        found_r <= 1'b1;
      end
      if (cmd.sq_step) begin
        sub_r <= stat.sub_last ? 2'd0 : sub_r + 2'd1;
      end
      if (pick_wr) begin
        chosen_r[best_idx_r] <= 1'b1;
        kept_r <= kept_r + KEPT_W'(1);
      end
      if (cmd.emit_seed) begin
        ptr_r <= '0;
      end else if (cmd.emit_pick) begin
        ptr_r <= ptr_r + KEPT_W'(1);
      end
      if (cmd.finish) begin
        count_r  <= '0;
        chosen_r <= '0;
        kept_r   <= '0;
      end
      if (cmd.emit_seed || cmd.emit_pick || cmd.emit_none) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rsq_r <= RSQ_W'(radius_r) * RSQ_W'(radius_r);
    end
    if (cmd.seed_cmp && ((idx_r == '0) || (rd_cand.id < seed_r.id))) begin
      seed_r     <= rd_cand;
      seed_idx_r <= idx_r;
    end
    if (cmd.sq_step) begin
      acc_r <= (sub_r == 2'd0) ? ACC_W'(prod) : acc_r + ACC_W'(prod);
    end
    if (cmd.rank_cmp && in_range && better) begin
      best_idx_r <= idx_r;
      best_id_r  <= rd_cand.id;
      bd_r       <= acc_r;
    end
    if (cmd.emit_seed || cmd.emit_pick) begin
      out_status      <= 1'b0;
      out_member_id   <= cmd.emit_seed ? seed_r.id : pick_data;
      out_group_map   <= seed_r.map;
      out_territory_x <= seed_r.x;
      out_territory_y <= seed_r.y;
      out_territory_z <= seed_r.z;
      out_last_member <= cmd.emit_seed ? stat.kept_zero : stat.emit_last;
    end else if (cmd.emit_none) begin
      out_status      <= 1'b1;
      out_member_id   <= '0;
      out_group_map   <= '0;
      out_territory_x <= '0;
      out_territory_y <= '0;
      out_territory_z <= '0;
      out_last_member <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  `RNGS_ASSERT_NOW(a_pick_within_limit, pick_wr, kept_r < limit, "pick beyond group limit")
  `RNGS_ASSERT_NEXT(a_finish_clears, cmd.finish, (chosen_r == '0) && (kept_r == '0), "not cleared")
  `RNGS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_member_id), "result lost")
endmodule

// File: hdl/rngs_ctrl.sv
// Controller: sequences loading, seed search, ranking passes and result output.
`include "radius_nearest_group_select_top_assert.svh"
module rngs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_final_candidate,
  output logic            in_ready,
  input  rngs_pkg::stat_t stat,
  output rngs_pkg::cmd_t  cmd
);
  import rngs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_START    = 14'h0002,
    S_SEED_RD  = 14'h0004,
    S_SEED_CMP = 14'h0008,
    S_RANK_BEG = 14'h0010,
    S_RANK_RD  = 14'h0020,
    S_RANK_CHK = 14'h0040,
    S_RANK_SQ  = 14'h0080,
    S_RANK_CMP = 14'h0100,
    S_PICK     = 14'h0200,
    S_DECIDE   = 14'h0400,
    S_EMIT_SD  = 14'h0800,
    S_PICK_RD  = 14'h1000,
    S_PICK_OUT = 14'h2000
  } state_t;

  state_t state_r, state_nxt;
  logic   nogrp_r, nogrp_nxt;

  always_comb begin
    state_nxt = state_r;
    nogrp_nxt = nogrp_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final_candidate) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (stat.too_few) begin
          nogrp_nxt = 1'b1;
          state_nxt = S_EMIT_SD;
        end else begin
          state_nxt = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SEED_CMP;
      end
      S_SEED_CMP: begin
        cmd.seed_cmp = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_RANK_BEG;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SEED_RD;
        end
      end
      S_RANK_BEG: begin
        cmd.pass_clr = 1'b1;
        state_nxt    = stat.limit_reached ? S_DECIDE : S_RANK_RD;
      end
      S_RANK_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RANK_CHK;
      end
      S_RANK_CHK: begin
        if (!stat.skip) begin
          state_nxt = S_RANK_SQ;
        end else if (stat.idx_last) begin
          state_nxt = S_PICK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RANK_RD;
        end
      end
      S_RANK_SQ: begin
        cmd.sq_step = 1'b1;
        if (stat.sub_last) begin
          state_nxt = S_RANK_CMP;
        end
      end
      S_RANK_CMP: begin
        cmd.rank_cmp = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_PICK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RANK_RD;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = stat.found ? S_RANK_BEG : S_DECIDE;
      end
      S_DECIDE: begin
        nogrp_nxt = stat.group_low;
        state_nxt = S_EMIT_SD;
      end
      S_EMIT_SD: begin
        if (stat.out_free) begin
          if (nogrp_r) begin
            cmd.emit_none = 1'b1;
            cmd.finish    = 1'b1;
            nogrp_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            cmd.emit_seed = 1'b1;
            if (stat.kept_zero) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_PICK_RD;
            end
          end
        end
      end
      S_PICK_RD: begin
        cmd.pick_rd = 1'b1;
        state_nxt   = S_PICK_OUT;
      end
      S_PICK_OUT: begin
        if (stat.out_free) begin
          cmd.emit_pick = 1'b1;
          if (stat.emit_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_PICK_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nogrp_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nogrp_r <= nogrp_nxt;
    end
  end

  `RNGS_ASSERT_NOW(a_cmp_after_sq, state_r == S_RANK_CMP, $past(state_r) == S_RANK_SQ, "bad compare")
  `RNGS_ASSERT_NEXT(a_pickout_after_rd, state_r == S_PICK_RD, state_r == S_PICK_OUT, "bad read")
  `RNGS_ASSERT_NOW(a_ready_only_idle, in_ready, state_r == S_IDLE, "request taken while busy")
endmodule

// File: hdl/radius_nearest_group_select_top.sv
// Top level of the radius nearest group selection block.
// Candidates are taken one per cycle while the block is idle; the request marked final starts a
// selection during which no request is accepted. The selection first walks the candidate store
// once to find the lowest-id seed, then runs one ranking pass per kept neighbour, plus a closing
// pass that finds none unless the size limit ends the search first; each pass reads every entry
// and measures those not skipped, building the squared distance with one shared multiplier, one
// axis per step. The seed result is given first, then one result per neighbour. With fewer
// candidates than the minimum, or too small a group, a single no-group result is given instead.
// Stores need no clearing after reset.
module radius_nearest_group_select_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rngs_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [rngs_pkg::CFG_D_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rngs_pkg::ID_W-1:0]  in_candidate_id,
  input  logic [rngs_pkg::MAP_W-1:0] in_map_number,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [rngs_pkg::POS_W-1:0] in_pos_z,
  input  logic                       in_final_candidate,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [rngs_pkg::ID_W-1:0]  out_member_id,
  output logic [rngs_pkg::MAP_W-1:0] out_group_map,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_x,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_y,
  output logic signed [rngs_pkg::POS_W-1:0] out_territory_z,
  output logic                       out_last_member
);
  import rngs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rngs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid),
    .in_final_candidate(in_final_candidate), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  rngs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_candidate_id(in_candidate_id), .in_map_number(in_map_number),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_member_id(out_member_id), .out_group_map(out_group_map),
    .out_territory_x(out_territory_x), .out_territory_y(out_territory_y),
    .out_territory_z(out_territory_z), .out_last_member(out_last_member)
  );
endmodule

// File: sim/radius_nearest_group_select_top_tb.sv
// Testbench for the radius nearest group selection block with a built-in group predictor.
module radius_nearest_group_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rngs_pkg::*;

  typedef struct {
    bit status;
    bit [ID_W-1:0] id;
    bit [MAP_W-1:0] map;
    bit [POS_W-1:0] tx;
    bit [POS_W-1:0] ty;
    bit [POS_W-1:0] tz;
    bit last;
  } member_t;

  class group_scoreboard;
    bit [ID_W-1:0] ids[MAX_CANDIDATES];
    bit [MAP_W-1:0] maps[MAX_CANDIDATES];
    logic signed [POS_W-1:0] px[MAX_CANDIDATES];
    logic signed [POS_W-1:0] py[MAX_CANDIDATES];
    logic signed [POS_W-1:0] pz[MAX_CANDIDATES];
    int stored = 0;
    int min_members = 2;
    int max_members = 8;
    longint radius = 7680;
    member_t due_members[$];
    int errors = 0;
    int checked = 0;
    int groups = 0;
    int no_groups = 0;

    function void set_reg(logic [CFG_A_W-1:0] idx, int val);
      case (idx)
        CFG_MIN_MEMBERS: min_members = val & 'h7f;
        CFG_MAX_MEMBERS: max_members = val & 'h7f;
        CFG_RADIUS: radius = val & 'h7fffff;
        default: ;
      endcase
    endfunction

    function longint dist_sq(int a, int s);
      longint dx, dy, dz;
      dx = longint'(px[a]) - longint'(px[s]);
      dy = longint'(py[a]) - longint'(py[s]);
      dz = longint'(pz[a]) - longint'(pz[s]);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void push_no_group();
      member_t m;
      m = '{1'b1, 0, 0, 0, 0, 0, 1'b1};
      due_members.insert(due_members.size(), m);
      no_groups++;
    endfunction

    function void note_candidate(bit [ID_W-1:0] id, bit [MAP_W-1:0] map,
                                 logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                 logic signed [POS_W-1:0] z, bit fin);
      int n, seed, lim, best;
      longint bd, d, rsq;
      bit taken[MAX_CANDIDATES];
      int picks[$];
      member_t m;
      if (stored < MAX_CANDIDATES) begin
        ids[stored] = id;
        maps[stored] = map;
        px[stored] = x;
        py[stored] = y;
        pz[stored] = z;
        stored++;
      end
      if (!fin) return;
      n = stored;
      stored = 0;
      if (n == 0 || n < min_members) begin
        push_no_group();
        return;
      end
      seed = 0;
      for (int i = 1; i < n; i++) if (ids[i] < ids[seed]) seed = i;
      foreach (taken[i]) taken[i] = 0;
      taken[seed] = 1;
      rsq = radius * radius;
      lim = (max_members < 1) ? 1 : (max_members > MAX_GROUP) ? MAX_GROUP : max_members;
      lim--;
      while (picks.size() < lim) begin
        best = n;
        bd = 0;
        for (int i = 0; i < n; i++) begin
          if (taken[i] || maps[i] != maps[seed]) continue;
          d = dist_sq(i, seed);
          if (d > rsq) continue;
          if (best == n || d < bd || (d == bd && ids[i] < ids[best])) begin
            best = i;
            bd = d;
          end
        end
        if (best == n) break;
        taken[best] = 1;
        picks.insert(picks.size(), best);
      end
      if (1 + picks.size() < min_members) begin
        push_no_group();
        return;
      end
      groups++;
      m = '{1'b0, ids[seed], maps[seed], px[seed], py[seed], pz[seed], picks.size() == 0};
      due_members.insert(due_members.size(), m);
      foreach (picks[k]) begin
        m.id = ids[picks[k]];
        m.last = (k == picks.size() - 1);
        due_members.insert(due_members.size(), m);
      end
    endfunction

    function bit field_ok(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
        return 0;
      end
      return 1;
    endfunction

    function void check_member(member_t got);
      member_t want;
      bit ok;
      checked++;
      if (due_members.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %h", $time, got.id);
        errors++;
        return;
      end
      want = due_members.pop_front();
      ok = field_ok("status", want.status, got.status);
      ok &= field_ok("member_id", want.id, got.id);
      ok &= field_ok("group_map", want.map, got.map);
      ok &= field_ok("territory_x", want.tx, got.tx);
      ok &= field_ok("territory_y", want.ty, got.ty);
      ok &= field_ok("territory_z", want.tz, got.tz);
      ok &= field_ok("last_member", want.last, got.last);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ID_W-1:0] in_candidate_id = '0;
  logic [MAP_W-1:0] in_map_number = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic in_final_candidate = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [ID_W-1:0] out_member_id;
  logic [MAP_W-1:0] out_group_map;
  logic signed [POS_W-1:0] out_territory_x;
  logic signed [POS_W-1:0] out_territory_y;
  logic signed [POS_W-1:0] out_territory_z;
  logic out_last_member;

  group_scoreboard board = new();
  bit calm = 0;
  int hold_left = 0;
  int cycles = 0;
  int sets_sent = 0;
  int items_sent = 0;
  bit [ID_W-1:0] prev_id = 0;

  radius_nearest_group_select_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else out_ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_member('{out_status, out_member_id, out_group_map, out_territory_x,
                           out_territory_y, out_territory_z, out_last_member});
  end

  task automatic send_cand(bit [ID_W-1:0] id, bit [MAP_W-1:0] map, bit [POS_W-1:0] x,
                           bit [POS_W-1:0] y, bit [POS_W-1:0] z, bit fin);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 31) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate_id <= id;
    in_map_number <= map;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_final_candidate <= fin;
    do @(posedge clk); while (!in_ready);
    board.note_candidate(id, map, x, y, z, fin);
    items_sent++;
    prev_id = id;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.due_members.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_D_W'(val);
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_config(int mn, int mx, int rad);
    wait_drained();
    write_reg(CFG_MIN_MEMBERS, mn);
    write_reg(CFG_MAX_MEMBERS, mx);
    write_reg(CFG_RADIUS, rad);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_set(int n, int spread);
    bit [MAP_W-1:0] home;
    bit [POS_W-1:0] cx, cy, cz;
    bit [ID_W-1:0] id;
    int mode;
    home = $urandom_range(3) == 0 ? MAP_W'($urandom()) : MAP_W'($urandom_range(3));
    cx = POS_W'($urandom());
    cy = POS_W'($urandom());
    cz = POS_W'($urandom());
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(19);
      id = (mode == 0 && i > 0) ? prev_id : $urandom();
      if (mode == 1)
        send_cand(id, MAP_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
                  POS_W'($urandom()), i == n - 1);
      else
        send_cand(id, mode == 2 ? MAP_W'(home + 1) : home,
                  POS_W'(cx + $urandom_range(2 * spread) - spread),
                  POS_W'(cy + $urandom_range(2 * spread) - spread),
                  POS_W'(cz + $urandom_range(2 * spread) - spread), i == n - 1);
    end
    sets_sent++;
  endtask

  initial begin
    int mn, mx, rad;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cand(32'h1234, 16'h0001, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    send_cand(32'hffffffff, 16'hffff, 24'h7fffff, 24'h800000, 24'h000100, 1'b0);
    send_cand(32'h00000000, 16'hffff, 24'h7fffff, 24'h800000, 24'h000000, 1'b0);
    send_cand(32'h00000010, 16'hffff, 24'h7fffff, 24'h800000, 24'h7fff00, 1'b0);
    send_cand(32'h00000005, 16'hffff, 24'h7fffff, 24'h800100, 24'h000000, 1'b0);
    send_cand(32'h00000003, 16'hffff, 24'h7ffeff, 24'h800000, 24'h000000, 1'b0);
    send_cand(32'h00000005, 16'hffff, 24'h7fffff, 24'h800000, 24'hffff00, 1'b0);
    send_cand(32'h00000001, 16'h0000, 24'h7fffff, 24'h800000, 24'h000000, 1'b1);
    set_config(0, 64, 8388607);
    send_cand(32'h00000002, 16'h0007, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_cand(32'h00000009, 16'h0007, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
    send_cand(32'h00000004, 16'h0007, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    set_config(1, 0, 0);
    send_cand(32'h00000020, 16'h0002, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_cand(32'h00000010, 16'h0002, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    set_config(3, 127, 0);
    send_cand(32'h00000020, 16'h0002, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_cand(32'h00000030, 16'h0002, 24'h000001, 24'h000000, 24'h000000, 1'b0);
    send_cand(32'h00000010, 16'h0002, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    set_config(64, 64, 7680);
    send_cand(32'h00000001, 16'h0002, 24'h000000, 24'h000000, 24'h000000, 1'b1);

    set_config(2, 64, 8388607);
    calm = 1;
    send_set(70, 4000000);
    calm = 0;
    set_config(2, 8, 7680);
    hold_left = 2000;
    send_set(12, 6000);

    while (items_sent < 225) begin
      if (sets_sent % 5 == 0) begin
        case ($urandom_range(4))
          0: mn = 0;
          1: mn = 1;
          2: mn = 2;
          3: mn = 3;
          default: mn = $urandom_range(64);
        endcase
        case ($urandom_range(6))
          0: mx = 0;
          1: mx = 1;
          2: mx = 3;
          3: mx = 64;
          4: mx = 127;
          default: mx = $urandom_range(1, 12);
        endcase
        case ($urandom_range(4))
          0: rad = 0;
          1: rad = $urandom_range(1, 300);
          2: rad = 8388607;
          default: rad = $urandom_range(7680, 100000);
        endcase
        set_config(mn, mx, rad);
      end
      calm = (sets_sent >= 14 && sets_sent < 22);
      send_set($urandom_range(1, 10), (board.radius < 16) ? 16 : int'(board.radius));
    end

    wait_drained();
    $display("Sent %0d candidates in %0d sets; checked %0d results, %0d groups, %0d no-group.",
             items_sent, sets_sent, board.checked, board.groups, board.no_groups);
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
